FILE: src/camc_pkg.sv
package camc_pkg;

    localparam int KEY_BITS     = 256;
    localparam int SUBKEY_COUNT = 34;
    localparam int ROUNDS       = 24;

    localparam logic [5:0] KW_BASE = 6'd0;
    localparam logic [5:0] K_BASE  = 6'd4;
    localparam logic [5:0] KE_BASE = 6'd28;

    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_IVH  = 3'd4;
    localparam logic [2:0] CFG_IVL  = 3'd5;
    localparam logic [2:0] CFG_DIR  = 3'd6;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
        logic        last_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        result_last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_ROUND,
        ST_FL,
        ST_DONE
    } t_state;

    localparam logic [63:0] SIGMA [6] = '{
        64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
        64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
    };

    localparam logic [7:0] SBOX1 [256] = '{
        8'd112, 8'd130, 8'd44,  8'd236, 8'd179, 8'd39,  8'd192, 8'd229,
        8'd228, 8'd133, 8'd87,  8'd53,  8'd234, 8'd12,  8'd174, 8'd65,
        8'd35,  8'd239, 8'd107, 8'd147, 8'd69,  8'd25,  8'd165, 8'd33,
        8'd237, 8'd14,  8'd79,  8'd78,  8'd29,  8'd101, 8'd146, 8'd189,
        8'd134, 8'd184, 8'd175, 8'd143, 8'd124, 8'd235, 8'd31,  8'd206,
        8'd62,  8'd48,  8'd220, 8'd95,  8'd94,  8'd197, 8'd11,  8'd26,
        8'd166, 8'd225, 8'd57,  8'd202, 8'd213, 8'd71,  8'd93,  8'd61,
        8'd217, 8'd1,   8'd90,  8'd214, 8'd81,  8'd86,  8'd108, 8'd77,
        8'd139, 8'd13,  8'd154, 8'd102, 8'd251, 8'd204, 8'd176, 8'd45,
        8'd116, 8'd18,  8'd43,  8'd32,  8'd240, 8'd177, 8'd132, 8'd153,
        8'd223, 8'd76,  8'd203, 8'd194, 8'd52,  8'd126, 8'd118, 8'd5,
        8'd109, 8'd183, 8'd169, 8'd49,  8'd209, 8'd23,  8'd4,   8'd215,
        8'd20,  8'd88,  8'd58,  8'd97,  8'd222, 8'd27,  8'd17,  8'd28,
        8'd50,  8'd15,  8'd156, 8'd22,  8'd83,  8'd24,  8'd242, 8'd34,
        8'd254, 8'd68,  8'd207, 8'd178, 8'd195, 8'd181, 8'd122, 8'd145,
        8'd36,  8'd8,   8'd232, 8'd168, 8'd96,  8'd252, 8'd105, 8'd80,
        8'd170, 8'd208, 8'd160, 8'd125, 8'd161, 8'd137, 8'd98,  8'd151,
        8'd84,  8'd91,  8'd30,  8'd149, 8'd224, 8'd255, 8'd100, 8'd210,
        8'd16,  8'd196, 8'd0,   8'd72,  8'd163, 8'd247, 8'd117, 8'd219,
        8'd138, 8'd3,   8'd230, 8'd218, 8'd9,   8'd63,  8'd221, 8'd148,
        8'd135, 8'd92,  8'd131, 8'd2,   8'd205, 8'd74,  8'd144, 8'd51,
        8'd115, 8'd103, 8'd246, 8'd243, 8'd157, 8'd127, 8'd191, 8'd226,
        8'd82,  8'd155, 8'd216, 8'd38,  8'd200, 8'd55,  8'd198, 8'd59,
        8'd129, 8'd150, 8'd111, 8'd75,  8'd19,  8'd190, 8'd99,  8'd46,
        8'd233, 8'd121, 8'd167, 8'd140, 8'd159, 8'd110, 8'd188, 8'd142,
        8'd41,  8'd245, 8'd249, 8'd182, 8'd47,  8'd253, 8'd180, 8'd89,
        8'd120, 8'd152, 8'd6,   8'd106, 8'd231, 8'd70,  8'd113, 8'd186,
        8'd212, 8'd37,  8'd171, 8'd66,  8'd136, 8'd162, 8'd141, 8'd250,
        8'd114, 8'd7,   8'd185, 8'd85,  8'd248, 8'd238, 8'd172, 8'd10,
        8'd54,  8'd73,  8'd42,  8'd104, 8'd60,  8'd56,  8'd241, 8'd164,
        8'd64,  8'd40,  8'd211, 8'd123, 8'd187, 8'd201, 8'd67,  8'd193,
        8'd21,  8'd227, 8'd173, 8'd244, 8'd119, 8'd199, 8'd128, 8'd158
    };

    function automatic logic [127:0] rotl128(logic [127:0] x, int n);
        rotl128 = (x << n) | (x >> (128 - n));
    endfunction

    // Subkeys are rotations of KL, KR, KA and KB by fixed amounts, taken in pairs.
    function automatic logic [63:0] subkey(logic [5:0] idx, logic [127:0] kl,
                                           logic [127:0] kr, logic [127:0] ka,
                                           logic [127:0] kb);
        logic [127:0] v;
        case (idx[5:1])
            5'd0:    v = kl;
            5'd1:    v = rotl128(kb, 111);
            5'd2:    v = kb;
            5'd3:    v = rotl128(kr, 15);
            5'd4:    v = rotl128(ka, 15);
            5'd5:    v = rotl128(kb, 30);
            5'd6:    v = rotl128(kl, 45);
            5'd7:    v = rotl128(ka, 45);
            5'd8:    v = rotl128(kr, 60);
            5'd9:    v = rotl128(kb, 60);
            5'd10:   v = rotl128(kl, 77);
            5'd11:   v = rotl128(kr, 94);
            5'd12:   v = rotl128(ka, 94);
            5'd13:   v = rotl128(kl, 111);
            5'd14:   v = rotl128(kr, 30);
            5'd15:   v = rotl128(kl, 60);
            5'd16:   v = rotl128(ka, 77);
            default: v = '0;
        endcase
        subkey = idx[0] ? v[63:0] : v[127:64];
    endfunction

    function automatic logic [63:0] fl(logic [63:0] x, logic [63:0] k);
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] t;
        x1 = x[63:32];
        x2 = x[31:0];
        t  = x1 & k[63:32];
        x2 = x2 ^ {t[30:0], t[31]};
        x1 = x1 ^ (x2 | k[31:0]);
        fl = {x1, x2};
    endfunction

    function automatic logic [63:0] flinv(logic [63:0] y, logic [63:0] k);
        logic [31:0] y1;
        logic [31:0] y2;
        logic [31:0] t;
        y1 = y[63:32];
        y2 = y[31:0];
        y1 = y1 ^ (y2 | k[31:0]);
        t  = y1 & k[63:32];
        y2 = y2 ^ {t[30:0], t[31]};
        flinv = {y1, y2};
    endfunction

endpackage

FILE: src/camc_f.sv
module camc_f (
    input  logic [63:0] i_x,
    input  logic [63:0] i_k,
    output logic [63:0] o_y
);

    logic [63:0] x;
    logic [7:0]  b [8];
    logic [7:0]  s [8];
    logic [7:0]  t [8];
    logic [7:0]  y [8];

    always_comb begin
        x = i_x ^ i_k;
        for (int i = 0; i < 8; i++) begin
            b[i] = x[63 - 8 * i -: 8];
        end
        // Bytes three and six are rotated before the lookup, not after.
        for (int i = 0; i < 8; i++) begin
            if (i == 3 || i == 6) begin
                s[i] = camc_pkg::SBOX1[{b[i][6:0], b[i][7]}];
            end else begin
                s[i] = camc_pkg::SBOX1[b[i]];
            end
        end
        t[0] = s[0];
        t[1] = {s[1][6:0], s[1][7]};
        t[2] = {s[2][0], s[2][7:1]};
        t[3] = s[3];
        t[4] = {s[4][6:0], s[4][7]};
        t[5] = {s[5][0], s[5][7:1]};
        t[6] = s[6];
        t[7] = s[7];
        y[0] = t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7];
        y[1] = t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7];
        y[2] = t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7];
        y[3] = t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
        y[4] = t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7];
        y[5] = t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7];
        y[6] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7];
        y[7] = t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
        o_y = {y[0], y[1], y[2], y[3], y[4], y[5], y[6], y[7]};
    end

endmodule

FILE: src/camellia_cbc_cipher.sv
// Camellia-256 in CBC mode, one 128-bit block per item. A single F-function unit
// serves both the key schedule and the cipher rounds, one F evaluation a cycle.
// An item is accepted with input whitening applied, then runs 24 rounds and 3 FL
// layers, then output whitening and chaining once the output register is free;
// ready is low meanwhile and rises as the result is registered, so a new item
// starts only after the last one is through. After reset, and after any write to
// a key register, the schedule of KA and KB runs before ready rises.
// The result sits in an output register, so the next item may start while it
// waits to be taken. A first_block item reloads the chain from the IV.
module camellia_cbc_cipher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  camc_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output camc_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    camc_pkg::t_state r_state, n_state;

    logic [63:0]  r_kw [4];
    logic [63:0]  r_iv_hi, r_iv_lo;
    logic         r_dir;
    logic         r_pend, n_pend;
    logic [127:0] r_ka, n_ka, r_kb, n_kb;
    logic [63:0]  r_d1, n_d1, r_d2, n_d2;
    logic [127:0] r_chain, n_chain, r_cin, n_cin;
    logic         r_last, n_last, r_dec, n_dec;
    logic [4:0]   r_cnt, n_cnt;
    logic         r_out_valid, n_out_valid;
    camc_pkg::t_out_item r_out, n_out;

    logic [127:0] kl, kr;
    logic [63:0]  f_in, f_key, f_out;
    logic [5:0]   rk_idx;
    logic [1:0]   layer;
    logic         in_acc, out_free, key_wr;
    logic [127:0] chain_eff, blk, res;
    logic [4:0]   cnt_inc;

    assign kl       = {r_kw[0], r_kw[1]};
    assign kr       = {r_kw[2], r_kw[3]};
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign key_wr   = i_cfg_we && (i_cfg_index == camc_pkg::CFG_KEY0 ||
                      i_cfg_index == camc_pkg::CFG_KEY1 ||
                      i_cfg_index == camc_pkg::CFG_KEY2 ||
                      i_cfg_index == camc_pkg::CFG_KEY3);
    assign cnt_inc  = r_cnt + 5'd1;

    camc_f u_f (
        .i_x (f_in),
        .i_k (f_key),
        .o_y (f_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw[0] <= '0;
            r_kw[1] <= '0;
            r_kw[2] <= '0;
            r_kw[3] <= '0;
            r_iv_hi <= '0;
            r_iv_lo <= '0;
            r_dir   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                camc_pkg::CFG_KEY0: r_kw[0] <= i_cfg_data;
                camc_pkg::CFG_KEY1: r_kw[1] <= i_cfg_data;
                camc_pkg::CFG_KEY2: r_kw[2] <= i_cfg_data;
                camc_pkg::CFG_KEY3: r_kw[3] <= i_cfg_data;
                camc_pkg::CFG_IVH:  r_iv_hi <= i_cfg_data;
                camc_pkg::CFG_IVL:  r_iv_lo <= i_cfg_data;
                camc_pkg::CFG_DIR:  r_dir   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            camc_pkg::ST_IDLE: begin
                if (r_pend) begin
                    n_state = camc_pkg::ST_KEY;
                end else if (i_in_valid) begin
                    n_state = camc_pkg::ST_ROUND;
                end
            end
            camc_pkg::ST_KEY: begin
                if (r_cnt == 5'd5) begin
                    n_state = camc_pkg::ST_IDLE;
                end
            end
            camc_pkg::ST_ROUND: begin
                if (r_cnt == 5'(camc_pkg::ROUNDS - 1)) begin
                    n_state = camc_pkg::ST_DONE;
                end else if (cnt_inc == 5'd6 || cnt_inc == 5'd12 || cnt_inc == 5'd18) begin
                    n_state = camc_pkg::ST_FL;
                end
            end
            camc_pkg::ST_FL: n_state = camc_pkg::ST_ROUND;
            camc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = camc_pkg::ST_IDLE;
                end
            end
            default: n_state = camc_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and the operands of the F unit.
    always_comb begin
        o_in_ready = (r_state == camc_pkg::ST_IDLE) && !r_pend;
        rk_idx     = camc_pkg::K_BASE + (r_dec ? 6'(5'd23 - r_cnt) : 6'(r_cnt));
        f_in       = r_cnt[0] ? r_d2 : r_d1;
        if (r_state == camc_pkg::ST_KEY) begin
            f_key = camc_pkg::SIGMA[r_cnt[2:0]];
        end else begin
            f_key = camc_pkg::subkey(rk_idx, kl, kr, r_ka, r_kb);
        end
    end

    always_comb begin
        case (r_cnt)
            5'd6:    layer = 2'd0;
            5'd12:   layer = 2'd1;
            default: layer = 2'd2;
        endcase
    end

    // Datapath.
    always_comb begin
        n_pend      = r_pend;
        n_ka        = r_ka;
        n_kb        = r_kb;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_chain     = r_chain;
        n_cin       = r_cin;
        n_last      = r_last;
        n_dec       = r_dec;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        chain_eff   = i_in.first_block ? {r_iv_hi, r_iv_lo} : r_chain;
        blk         = r_dir ? {i_in.block_high, i_in.block_low}
                            : {i_in.block_high, i_in.block_low} ^ chain_eff;
        res         = {r_d2 ^ camc_pkg::subkey(camc_pkg::KW_BASE + (r_dec ? 6'd0 : 6'd2),
                                               kl, kr, r_ka, r_kb),
                       r_d1 ^ camc_pkg::subkey(camc_pkg::KW_BASE + (r_dec ? 6'd1 : 6'd3),
                                               kl, kr, r_ka, r_kb)};
        unique case (r_state)
            camc_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (r_pend) begin
                    n_pend = 1'b0;
                    n_d1   = r_kw[0] ^ r_kw[2];
                    n_d2   = r_kw[1] ^ r_kw[3];
                end else if (in_acc) begin
                    n_chain = chain_eff;
                    n_cin   = {i_in.block_high, i_in.block_low};
                    n_last  = i_in.last_block;
                    n_dec   = r_dir;
                    n_d1    = blk[127:64] ^ camc_pkg::subkey(
                                  camc_pkg::KW_BASE + (r_dir ? 6'd2 : 6'd0),
                                  kl, kr, r_ka, r_kb);
                    n_d2    = blk[63:0] ^ camc_pkg::subkey(
                                  camc_pkg::KW_BASE + (r_dir ? 6'd3 : 6'd1),
                                  kl, kr, r_ka, r_kb);
                end
            end
            camc_pkg::ST_KEY: begin
                n_cnt = cnt_inc;
                if (!r_cnt[0]) begin
                    n_d2 = r_d2 ^ f_out;
                end else begin
                    n_d1 = r_d1 ^ f_out;
                end
                // KA is complete after the fourth step and KB after the sixth.
                case (r_cnt)
                    5'd1: begin
                        n_d1 = r_d1 ^ f_out ^ r_kw[0];
                        n_d2 = r_d2 ^ r_kw[1];
                    end
                    5'd3: begin
                        n_ka = {r_d1 ^ f_out, r_d2};
                        n_d1 = r_d1 ^ f_out ^ r_kw[2];
                        n_d2 = r_d2 ^ r_kw[3];
                    end
                    5'd5: n_kb = {r_d1 ^ f_out, r_d2};
                    default: ;
                endcase
            end
            camc_pkg::ST_ROUND: begin
                n_cnt = cnt_inc;
                if (!r_cnt[0]) begin
                    n_d2 = r_d2 ^ f_out;
                end else begin
                    n_d1 = r_d1 ^ f_out;
                end
            end
            camc_pkg::ST_FL: begin
                n_d1 = camc_pkg::fl(r_d1, camc_pkg::subkey(camc_pkg::KE_BASE +
                           (r_dec ? 6'(3'd5 - {layer, 1'b0}) : 6'({layer, 1'b0})),
                           kl, kr, r_ka, r_kb));
                n_d2 = camc_pkg::flinv(r_d2, camc_pkg::subkey(camc_pkg::KE_BASE +
                           (r_dec ? 6'(3'd4 - {layer, 1'b0}) : 6'({layer, 1'b1})),
                           kl, kr, r_ka, r_kb));
            end
            camc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_last = r_last;
                    if (r_dec) begin
                        {n_out.result_high, n_out.result_low} = res ^ r_chain;
                        n_chain = r_cin;
                    end else begin
                        {n_out.result_high, n_out.result_low} = res;
                        n_chain = res;
                    end
                end
            end
            default: ;
        endcase
        if (key_wr) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= camc_pkg::ST_IDLE;
            r_pend      <= 1'b1;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ka   <= n_ka;
        r_kb   <= n_kb;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_cin  <= n_cin;
        r_last <= n_last;
        r_dec  <= n_dec;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/camc_checker.sv
module camc_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input camc_pkg::t_out_item o_out
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready high in the cycle after an item was accepted");

    // The key schedule must run before the first item after reset.
    a_not_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("ready high straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out))
        else $error("stalled result changed");

endmodule

bind camellia_cbc_cipher camc_props u_camc_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

FILE: bench/camc_checker.sv
module camc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  camc_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  camc_pkg::t_out_item i_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] SB [256] = '{
        112,130, 44,236,179, 39,192,229,228,133, 87, 53,234, 12,174, 65,
         35,239,107,147, 69, 25,165, 33,237, 14, 79, 78, 29,101,146,189,
        134,184,175,143,124,235, 31,206, 62, 48,220, 95, 94,197, 11, 26,
        166,225, 57,202,213, 71, 93, 61,217,  1, 90,214, 81, 86,108, 77,
        139, 13,154,102,251,204,176, 45,116, 18, 43, 32,240,177,132,153,
        223, 76,203,194, 52,126,118,  5,109,183,169, 49,209, 23,  4,215,
         20, 88, 58, 97,222, 27, 17, 28, 50, 15,156, 22, 83, 24,242, 34,
        254, 68,207,178,195,181,122,145, 36,  8,232,168, 96,252,105, 80,
        170,208,160,125,161,137, 98,151, 84, 91, 30,149,224,255,100,210,
         16,196,  0, 72,163,247,117,219,138,  3,230,218,  9, 63,221,148,
        135, 92,131,  2,205, 74,144, 51,115,103,246,243,157,127,191,226,
         82,155,216, 38,200, 55,198, 59,129,150,111, 75, 19,190, 99, 46,
        233,121,167,140,159,110,188,142, 41,245,249,182, 47,253,180, 89,
        120,152,  6,106,231, 70,113,186,212, 37,171, 66,136,162,141,250,
        114,  7,185, 85,248,238,172, 10, 54, 73, 42,104, 60, 56,241,164,
         64, 40,211,123,187,201, 67,193, 21,227,173,244,119,199,128,158
    };
    localparam logic [63:0] SG [6] = '{
        64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
        64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
    };

    logic [63:0]  key_regs [4];
    logic [63:0]  iv_hi, iv_lo;
    logic         decrypting;
    logic [127:0] chain;
    logic [63:0]  sched [34];
    camc_pkg::t_out_item expected_blocks [$];

    function automatic logic [7:0] r8(logic [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [63:0] round_f(logic [63:0] din, logic [63:0] k);
        logic [63:0] x;
        logic [7:0]  t [8];
        logic [7:0]  y [8];
        x = din ^ k;
        for (int i = 0; i < 8; i++) t[i] = x[63 - 8 * i -: 8];
        t[0] = SB[t[0]];
        t[1] = r8(SB[t[1]], 1);
        t[2] = r8(SB[t[2]], 7);
        t[3] = SB[r8(t[3], 1)];
        t[4] = r8(SB[t[4]], 1);
        t[5] = r8(SB[t[5]], 7);
        t[6] = SB[r8(t[6], 1)];
        t[7] = SB[t[7]];
        y[0] = t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7];
        y[1] = t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7];
        y[2] = t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7];
        y[3] = t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
        y[4] = t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7];
        y[5] = t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7];
        y[6] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7];
        y[7] = t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
        return {y[0], y[1], y[2], y[3], y[4], y[5], y[6], y[7]};
    endfunction

    function automatic logic [63:0] mix_fl(logic [63:0] v, logic [63:0] k, bit inv);
        logic [31:0] a, b, t;
        a = v[63:32];
        b = v[31:0];
        if (!inv) begin
            t = a & k[63:32];
            b ^= {t[30:0], t[31]};
            a ^= b | k[31:0];
        end else begin
            a ^= b | k[31:0];
            t = a & k[63:32];
            b ^= {t[30:0], t[31]};
        end
        return {a, b};
    endfunction

    function automatic logic [127:0] rot(logic [127:0] v, int n);
        return n == 0 ? v : (v << n) | (v >> (128 - n));
    endfunction

    task automatic rebuild_schedule();
        logic [127:0] kl, kr, ka, kb;
        logic [63:0]  d1, d2;
        logic [127:0] parts [17];
        kl = {key_regs[0], key_regs[1]};
        kr = {key_regs[2], key_regs[3]};
        d1 = kl[127:64] ^ kr[127:64];
        d2 = kl[63:0] ^ kr[63:0];
        d2 ^= round_f(d1, SG[0]);
        d1 ^= round_f(d2, SG[1]);
        d1 ^= kl[127:64];
        d2 ^= kl[63:0];
        d2 ^= round_f(d1, SG[2]);
        d1 ^= round_f(d2, SG[3]);
        ka = {d1, d2};
        d1 ^= kr[127:64];
        d2 ^= kr[63:0];
        d2 ^= round_f(d1, SG[4]);
        d1 ^= round_f(d2, SG[5]);
        kb = {d1, d2};
        parts = '{kl, rot(kb, 111), kb, rot(kr, 15), rot(ka, 15), rot(kb, 30),
                  rot(kl, 45), rot(ka, 45), rot(kr, 60), rot(kb, 60), rot(kl, 77),
                  rot(kr, 94), rot(ka, 94), rot(kl, 111), rot(kr, 30), rot(kl, 60),
                  rot(ka, 77)};
        for (int i = 0; i < 17; i++) begin
            sched[2 * i]     = parts[i][127:64];
            sched[2 * i + 1] = parts[i][63:0];
        end
    endtask

    function automatic logic [127:0] cipher_block(logic [127:0] blk, bit dec);
        logic [63:0] d1, d2;
        int pre, post, ia, ib, ea, eb, layer;
        pre = dec ? 2 : 0;
        post = dec ? 0 : 2;
        layer = 0;
        d1 = blk[127:64] ^ sched[pre];
        d2 = blk[63:0] ^ sched[pre + 1];
        for (int r = 0; r < 24; r += 2) begin
            ia = dec ? 23 - r : r;
            ib = dec ? 22 - r : r + 1;
            if (r != 0 && r % 6 == 0) begin
                ea = dec ? 5 - 2 * layer : 2 * layer;
                eb = dec ? 4 - 2 * layer : 2 * layer + 1;
                d1 = mix_fl(d1, sched[28 + ea], 1'b0);
                d2 = mix_fl(d2, sched[28 + eb], 1'b1);
                layer++;
            end
            d2 ^= round_f(d1, sched[4 + ia]);
            d1 ^= round_f(d2, sched[4 + ib]);
        end
        return {d2 ^ sched[post], d1 ^ sched[post + 1]};
    endfunction

    assign o_pending = expected_blocks.size();

    always @(posedge i_clk) begin
        camc_pkg::t_out_item exp_item;
        logic [127:0] res;
        if (!i_rst_n) begin
            key_regs = '{default: '0};
            iv_hi = '0;
            iv_lo = '0;
            decrypting = 1'b0;
            chain = '0;
            rebuild_schedule();
            expected_blocks.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    camc_pkg::CFG_KEY0, camc_pkg::CFG_KEY1,
                    camc_pkg::CFG_KEY2, camc_pkg::CFG_KEY3: begin
                        key_regs[i_cfg_index[1:0]] = i_cfg_data;
                        rebuild_schedule();
                    end
                    camc_pkg::CFG_IVH: iv_hi = i_cfg_data;
                    camc_pkg::CFG_IVL: iv_lo = i_cfg_data;
                    camc_pkg::CFG_DIR: decrypting = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.first_block) chain = {iv_hi, iv_lo};
                if (!decrypting) begin
                    res = cipher_block({i_in.block_high, i_in.block_low} ^ chain, 1'b0);
                    chain = res;
                end else begin
                    res = cipher_block({i_in.block_high, i_in.block_low}, 1'b1) ^ chain;
                    chain = {i_in.block_high, i_in.block_low};
                end
                expected_blocks.push_back('{res[127:64], res[63:0], i_in.last_block});
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_blocks.pop_front();
                    if (exp_item !== i_out) begin
                        $display("%0t: mismatch expected %h_%h last %b, actual %h_%h last %b",
                                 $time, exp_item.result_high, exp_item.result_low,
                                 exp_item.result_last, i_out.result_high,
                                 i_out.result_low, i_out.result_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    camc_pkg::t_in_item  in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    camc_pkg::t_out_item out_item;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = camc_pkg::CFG_KEY0;
    logic [63:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    bit          hold_start = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    camellia_cbc_cipher u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    camc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver runs on its own; a long hold-off stalls it regardless of the odds.
    always @(posedge clk) begin
        if (hold_start && hold_cycles < 400) begin
            hold_cycles <= hold_cycles + 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(logic [63:0] hi, logic [63:0] lo, bit first, bit last);
        cfg_we <= 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item <= '{hi, lo, first, last};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        cfg_we <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_config();
        for (int r = camc_pkg::CFG_KEY0; r <= camc_pkg::CFG_DIR; r++) begin
            if ($urandom_range(2) != 0) write_reg(r[2:0], rand64());
        end
        write_reg(camc_pkg::CFG_DIR, 64'($urandom_range(1)));
    endtask

    // Mostly well-formed messages; sometimes a flag is dropped to break the chain.
    task automatic random_items(int count);
        int left;
        bit first, last;
        while (count > 0) begin
            left = $urandom_range(1, 12);
            for (int i = 0; i < left && count > 0; i++) begin
                first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
                last = (i == left - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
                send_item(rand64(), rand64(), first, last);
                count--;
            end
        end
    endtask

    initial begin
        logic [63:0] corner [4];
        corner = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h1};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero key, no first-block flag: chain starts from zero.
        send_item('0, '0, 1'b0, 1'b0);
        send_item('1, '1, 1'b0, 1'b1);
        drain();
        for (int r = camc_pkg::CFG_KEY0; r <= camc_pkg::CFG_IVL; r++) write_reg(r[2:0], '1);
        for (int i = 0; i < 4; i++) send_item(corner[i], corner[3 - i], i == 0, i == 3);
        // Key change mid-message keeps the chain.
        drain();
        write_reg(camc_pkg::CFG_KEY2, 64'h0123_4567_89AB_CDEF);
        send_item('1, '0, 1'b0, 1'b0);
        drain();
        // IV change mid-message only matters at the next first block.
        write_reg(camc_pkg::CFG_IVH, '0);
        send_item('0, '1, 1'b0, 1'b0);
        send_item('0, '1, 1'b1, 1'b0);
        // Direction change mid-message keeps the chain.
        drain();
        write_reg(camc_pkg::CFG_DIR, 64'd1);
        for (int i = 0; i < 4; i++) send_item(corner[i], corner[i], i == 0, i == 3);
        drain();
        write_reg(camc_pkg::CFG_DIR, 64'd0);
        send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1);
        drain();
        write_reg(3'd7, '1);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            random_config();
            if (phase == 4) hold_start = 1'b1;
            random_items(225);
            drain();
        end

        if (fail_count == 0) begin
            $display("** camellia_cbc_cipher: PASSED **");
        end else begin
            $display("** camellia_cbc_cipher: FAILED **");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("** camellia_cbc_cipher: FAILED **");
        $finish;
    end
endmodule
